// ----- rtl/core/ndrd_pkg.sv -----
`timescale 1ns / 1ps

package ndrd_pkg;

   // Largest legal length or offset field, in bytes
   localparam logic [3:0] MAX_FIELD_BYTES = 4'd8;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLUSTER_SECTORS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARTITION_START   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILE_BYTES        = 2'd2;

   localparam logic [7:0] CLUSTER_SECTORS_RESET = 8'd8;

   // Parser phase, one-hot
   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_LENGTH = 4'b0010,
      PH_OFFSET = 4'b0100,
      PH_HALT   = 4'b1000
   } phase_type;

   // One classified request handed from the parser to the address unit
   typedef struct packed {
      logic        restart;   // reload the remaining count before this entry
      logic [47:0] load;      // file size captured at list start
      logic        is_run;
      logic        is_end;
      logic        is_mal;
      logic        sparse;
      logic [63:0] len;       // run length in clusters
      logic [63:0] cluster;   // absolute cluster number
   } run_entry_type;

endpackage

// ----- rtl/core/ndrd_front.sv -----
`timescale 1ns / 1ps

module ndrd_front import ndrd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_run_byte,
   input  logic          req_list_start,
   input  logic [47:0]   file_bytes,
   input  logic          queue_full,
   output logic          push,
   output run_entry_type push_entry
);

   // Sign-extend a little-endian field of n bytes (n = 1..8)
   function automatic logic [63:0] sext_field(input logic [63:0] v, input logic [3:0] n);
      logic [63:0] r;
      logic [5:0]  sidx;
      logic        sgn;
      r    = v;
      sidx = {3'(n - 4'd1), 3'b111};
      sgn  = v[sidx];
      for (int i = 0; i < 8; i++) begin
         if (4'(i) >= n) begin
            r[8*i +: 8] = {8{sgn}};
         end
      end
      return r;
   endfunction

   phase_type   phase_ff, phase_in;
   logic [3:0]  lsz_ff, lsz_in;
   logic [3:0]  osz_ff, osz_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] len_ff, len_in;
   logic [63:0] off_ff, off_in;
   logic [63:0] prev_ff, prev_in;
   logic        pend_ff, pend_in;
   logic [47:0] load_ff, load_in;

   logic        accept;
   phase_type   phase_eff;
   logic [63:0] prev_eff;
   logic        pend_eff;
   logic [47:0] load_eff;
   logic [63:0] shifted;
   logic [3:0]  cnt_nx;
   logic [63:0] len_new;
   logic [63:0] off_new;
   logic [63:0] cluster_sum;
   logic [3:0]  lo_nib;
   logic [3:0]  hi_nib;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // A start flag restarts parsing on this very byte
   assign phase_eff = req_list_start ? PH_HEADER : phase_ff;
   assign prev_eff  = req_list_start ? 64'd0 : prev_ff;
   assign pend_eff  = req_list_start || pend_ff;
   assign load_eff  = req_list_start ? file_bytes : load_ff;

   assign lo_nib      = req_run_byte[3:0];
   assign hi_nib      = req_run_byte[7:4];
   assign shifted     = {56'd0, req_run_byte} << {cnt_ff[2:0], 3'b000};
   assign cnt_nx      = cnt_ff + 4'd1;
   assign len_new     = len_ff | shifted;
   assign off_new     = off_ff | shifted;
   assign cluster_sum = prev_eff + sext_field(off_new, osz_ff);

   // Parser
   always_comb begin
      phase_in   = phase_ff;
      lsz_in     = lsz_ff;
      osz_in     = osz_ff;
      cnt_in     = cnt_ff;
      len_in     = len_ff;
      off_in     = off_ff;
      prev_in    = prev_ff;
      pend_in    = pend_ff;
      load_in    = load_ff;
      push       = 1'b0;
      push_entry = '0;
      push_entry.restart = pend_eff;
      push_entry.load    = load_eff;
      if (accept) begin
         prev_in  = prev_eff;
         pend_in  = pend_eff;
         load_in  = load_eff;
         phase_in = phase_eff;
         unique case (phase_eff)
            PH_HEADER: begin
               if (req_run_byte == 8'd0) begin
                  push              = 1'b1;
                  push_entry.is_end = 1'b1;
                  phase_in          = PH_HALT;
               end else if (lo_nib > MAX_FIELD_BYTES || hi_nib > MAX_FIELD_BYTES) begin
                  push              = 1'b1;
                  push_entry.is_mal = 1'b1;
                  phase_in          = PH_HALT;
               end else begin
                  lsz_in   = lo_nib;
                  osz_in   = hi_nib;
                  len_in   = 64'd0;
                  off_in   = 64'd0;
                  cnt_in   = 4'd0;
                  phase_in = (lo_nib != 4'd0) ? PH_LENGTH : PH_OFFSET;
               end
            end
            PH_LENGTH: begin
               len_in = len_new;
               cnt_in = cnt_nx;
               if (cnt_nx >= lsz_ff) begin
                  if (osz_ff == 4'd0) begin
                     // sparse run: cluster number stays
                     push              = 1'b1;
                     push_entry.is_run = 1'b1;
                     push_entry.sparse = 1'b1;
                     push_entry.len    = len_new;
                     push_entry.cluster = prev_eff;
                     phase_in          = PH_HEADER;
                  end else begin
                     cnt_in   = 4'd0;
                     phase_in = PH_OFFSET;
                  end
               end
            end
            PH_OFFSET: begin
               off_in = off_new;
               cnt_in = cnt_nx;
               if (cnt_nx >= osz_ff) begin
                  push               = 1'b1;
                  push_entry.is_run  = 1'b1;
                  push_entry.len     = len_ff;
                  push_entry.cluster = cluster_sum;
                  prev_in            = cluster_sum;
                  phase_in           = PH_HEADER;
               end
            end
            PH_HALT: begin
               phase_in = PH_HALT;
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
         if (push) begin
            pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         lsz_ff   <= 4'd0;
         osz_ff   <= 4'd0;
         cnt_ff   <= 4'd0;
         len_ff   <= 64'd0;
         off_ff   <= 64'd0;
         prev_ff  <= 64'd0;
         pend_ff  <= 1'b0;
         load_ff  <= 48'd0;
      end else begin
         phase_ff <= phase_in;
         lsz_ff   <= lsz_in;
         osz_ff   <= osz_in;
         cnt_ff   <= cnt_in;
         len_ff   <= len_in;
         off_ff   <= off_in;
         prev_ff  <= prev_in;
         pend_ff  <= pend_in;
         load_ff  <= load_in;
      end
   end

endmodule

// ----- rtl/core/ndrd_queue.sv -----
`timescale 1ns / 1ps

module ndrd_queue import ndrd_pkg::*; #(
   parameter int unsigned DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  run_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          out_valid,
   output run_entry_type out_entry
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   run_entry_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_pop;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_entry = slot_ff[rd_ff];
   assign do_pop    = pop && out_valid;

   // Pointer and fill count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == LAST) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/core/ndrd_back.sv -----
`timescale 1ns / 1ps

module ndrd_back import ndrd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  run_entry_type q_entry,
   output logic          q_pop,
   input  logic [7:0]    cluster_sectors,
   input  logic [31:0]   partition_start_sector,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [63:0]   rsp_disk_address,
   output logic [63:0]   rsp_run_clusters,
   output logic [47:0]   rsp_copy_bytes,
   output logic          rsp_sparse_run,
   output logic          rsp_end_of_list,
   output logic          rsp_malformed
);

   logic        advance;

   // stage 1: products
   logic        s1_valid_ff;
   logic        s1_restart_ff;
   logic [47:0] s1_load_ff;
   logic        s1_is_run_ff;
   logic        s1_end_ff;
   logic        s1_mal_ff;
   logic        s1_sparse_ff;
   logic [63:0] s1_len_ff;
   logic [63:0] s1_cl_mul_ff;
   logic [54:0] s1_run_mul_ff;
   logic        s1_big_ff;

   logic [63:0] cl_mul_in;
   logic [54:0] run_mul_in;
   logic        big_in;

   // stage 2: remaining count and output register
   logic [47:0] rem_ff, rem_in;
   logic [47:0] rem_eff;
   logic [63:0] run_size;
   logic [47:0] copy;
   logic [63:0] addr_sum;

   logic        out_valid_ff;
   logic [63:0] out_addr_ff;
   logic [63:0] out_len_ff;
   logic [47:0] out_copy_ff;
   logic        out_sparse_ff;
   logic        out_end_ff;
   logic        out_mal_ff;

   assign advance = !out_valid_ff || !rsp_stall;
   assign q_pop   = q_valid && advance;

   // cluster times sectors; the factor of 512 is a shift in stage 2
   assign cl_mul_in  = q_entry.cluster * {56'd0, cluster_sectors};
   assign run_mul_in = {8'd0, q_entry.len[46:0]} * {47'd0, cluster_sectors};
   assign big_in     = (|q_entry.len[63:47]) && (cluster_sectors != 8'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_restart_ff <= q_entry.restart;
         s1_load_ff    <= q_entry.load;
         s1_is_run_ff  <= q_entry.is_run;
         s1_end_ff     <= q_entry.is_end;
         s1_mal_ff     <= q_entry.is_mal;
         s1_sparse_ff  <= q_entry.sparse;
         s1_len_ff     <= q_entry.len;
         s1_cl_mul_ff  <= cl_mul_in;
         s1_run_mul_ff <= run_mul_in;
         s1_big_ff     <= big_in;
      end
   end

   // Copy size: min of run size and bytes left, run size saturating
   always_comb begin
      rem_eff  = s1_restart_ff ? s1_load_ff : rem_ff;
      run_size = {s1_run_mul_ff, 9'd0};
      if (s1_big_ff) begin
         copy = rem_eff;
      end else if (run_size < {16'd0, rem_eff}) begin
         copy = run_size[47:0];
      end else begin
         copy = rem_eff;
      end
      rem_in   = rem_ff;
      if (s1_valid_ff && advance) begin
         rem_in = rem_eff - copy;
      end
      addr_sum = {23'd0, partition_start_sector, 9'd0} + {s1_cl_mul_ff[54:0], 9'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= 48'd0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff <= rem_in;
         if (advance) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         out_addr_ff   <= (s1_is_run_ff && !s1_sparse_ff) ? addr_sum : 64'd0;
         out_len_ff    <= s1_len_ff;
         out_copy_ff   <= copy;
         out_sparse_ff <= s1_sparse_ff;
         out_end_ff    <= s1_end_ff;
         out_mal_ff    <= s1_mal_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_disk_address = out_addr_ff;
   assign rsp_run_clusters = out_len_ff;
   assign rsp_copy_bytes   = out_copy_ff;
   assign rsp_sparse_run   = out_sparse_ff;
   assign rsp_end_of_list  = out_end_ff;
   assign rsp_malformed    = out_mal_ff;

endmodule

// ----- rtl/core/ntfs_data_run_decoder_core.sv -----
`timescale 1ns / 1ps

// NTFS run list decoder.
// Request channel (req_valid / req_stall): one run-list byte per request,
// with req_list_start marking the first byte of a new list. Response
// channel (rsp_valid / rsp_stall): one response per completed run, per
// zero header byte (end of list) and per oversize header (malformed).
// Bytes that complete nothing give no response.
// Throughput: one byte per cycle while req_stall is low. The parser keeps
// cluster number and field state in flops and finishes each byte in its
// cycle; the address unit behind it runs a two-stage pipeline (products
// with the 8-bit sector count, then the remaining-count subtract and
// address add). A response passes through the queue slot, the stage-1
// registers and the output register before rsp_valid rises.
// A small queue sits between parser and address unit; when the receiver
// stalls, the output register holds, the pipeline freezes, and once the
// queue fills req_stall rises. Nothing is dropped. Configuration
// (csr_write / csr_index / csr_wdata) is written while idle by the user;
// the block does not enforce it. Reset: synchronous; clears parser, queue
// and pipeline; cluster_sectors to 8, partition start and file size to 0.
module ntfs_data_run_decoder_core import ndrd_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_run_byte,
   input  logic                   req_list_start,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [63:0]            rsp_disk_address,
   output logic [63:0]            rsp_run_clusters,
   output logic [47:0]            rsp_copy_bytes,
   output logic                   rsp_sparse_run,
   output logic                   rsp_end_of_list,
   output logic                   rsp_malformed,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [47:0]            csr_wdata
);

   logic [7:0]    cluster_sectors_ff;
   logic [31:0]   partition_start_ff;
   logic [47:0]   file_bytes_ff;

   logic          q_full;
   logic          q_push;
   run_entry_type q_push_entry;
   logic          q_pop;
   logic          q_valid;
   run_entry_type q_entry;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_sectors_ff <= CLUSTER_SECTORS_RESET;
         partition_start_ff <= 32'd0;
         file_bytes_ff      <= 48'd0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CLUSTER_SECTORS: cluster_sectors_ff <= csr_wdata[7:0];
            CSR_PARTITION_START: partition_start_ff <= csr_wdata[31:0];
            CSR_FILE_BYTES:      file_bytes_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   ndrd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_run_byte   (req_run_byte),
      .req_list_start (req_list_start),
      .file_bytes     (file_bytes_ff),
      .queue_full     (q_full),
      .push           (q_push),
      .push_entry     (q_push_entry)
   );

   ndrd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .out_valid  (q_valid),
      .out_entry  (q_entry)
   );

   ndrd_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .q_valid                (q_valid),
      .q_entry                (q_entry),
      .q_pop                  (q_pop),
      .cluster_sectors        (cluster_sectors_ff),
      .partition_start_sector (partition_start_ff),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_disk_address       (rsp_disk_address),
      .rsp_run_clusters       (rsp_run_clusters),
      .rsp_copy_bytes         (rsp_copy_bytes),
      .rsp_sparse_run         (rsp_sparse_run),
      .rsp_end_of_list        (rsp_end_of_list),
      .rsp_malformed          (rsp_malformed)
   );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import ndrd_pkg::*;

   // Expected response, one per completed run, end marker or bad header
   typedef struct packed {
      logic [63:0] disk_address;
      logic [63:0] run_clusters;
      logic [47:0] copy_bytes;
      logic        sparse_run;
      logic        end_of_list;
      logic        malformed;
   } run_result_type;

   // One row of the directed request table
   typedef struct {
      logic [7:0]     run_byte;
      logic           list_start;
      bit             typed;
      run_result_type want;
   } stim_row_type;

   localparam run_result_type LIST_END   = '{end_of_list: 1'b1, default: '0};
   localparam run_result_type BAD_HEADER = '{malformed: 1'b1, default: '0};
   localparam run_result_type EARLY_SPARSE = '{run_clusters: 64'd3, sparse_run: 1'b1,
                                               default: '0};

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [7:0]             req_run_byte;
   logic                   req_list_start;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [63:0]            rsp_disk_address;
   logic [63:0]            rsp_run_clusters;
   logic [47:0]            rsp_copy_bytes;
   logic                   rsp_sparse_run;
   logic                   rsp_end_of_list;
   logic                   rsp_malformed;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [47:0]            csr_wdata;

   ntfs_data_run_decoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_run_byte     (req_run_byte),
      .req_list_start   (req_list_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_disk_address (rsp_disk_address),
      .rsp_run_clusters (rsp_run_clusters),
      .rsp_copy_bytes   (rsp_copy_bytes),
      .rsp_sparse_run   (rsp_sparse_run),
      .rsp_end_of_list  (rsp_end_of_list),
      .rsp_malformed    (rsp_malformed),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Register copies kept by the run list predictor
   logic [7:0]  cfg_cluster_sectors = CLUSTER_SECTORS_RESET;
   logic [31:0] cfg_partition_start = '0;
   logic [47:0] cfg_file_bytes      = '0;

   // Parser state of the predictor
   phase_type   parse_phase  = PH_HEADER;
   logic [3:0]  len_size     = '0;
   logic [3:0]  off_size     = '0;
   logic [3:0]  field_count  = '0;
   logic [63:0] len_accum    = '0;
   logic [63:0] off_accum    = '0;
   logic [63:0] prev_cluster = '0;
   logic [47:0] bytes_left   = '0;

   run_result_type pending_runs [$];
   int             mismatches    = 0;
   int             live_requests = 0;
   bit             gaps_on       = 1'b1;
   bit             hold_off      = 1'b0;

   stim_row_type directed_rows [27] = '{
      // before any list start: parsed with nothing left to copy
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'h03, 1'b0, 1'b1, EARLY_SPARSE},
      '{8'h00, 1'b0, 1'b1, LIST_END},
      '{8'h11, 1'b0, 1'b0, '0},            // ignored after end
      // positive two-byte offset
      '{8'h21, 1'b1, 1'b0, '0},
      '{8'h10, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h7F, 1'b0, 1'b0, '0},
      // negative one-byte offset
      '{8'h11, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b0, '0},
      // sparse run
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'h05, 1'b0, 1'b0, '0},
      // empty length field
      '{8'h10, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      // eight-byte length, run size saturates
      '{8'h18, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      // oversize length nibble, then oversize offset nibble
      '{8'h19, 1'b1, 1'b1, BAD_HEADER},
      '{8'h90, 1'b1, 1'b1, BAD_HEADER}
   };

   // 100 MHz clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 100)
         $display("%0t ns: mismatch: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
   endtask

   // Address and copy count of a completed run; advances the cluster number unless the run is sparse
   function automatic run_result_type finish_run();
      logic [63:0] cluster_bytes, offset, cluster, run_bytes;
      logic [47:0] copy;
      run_result_type r;
      r = '0;
      cluster_bytes = 64'(cfg_cluster_sectors) * 64'd512;
      cluster = prev_cluster;
      offset = off_accum;
      if (off_size != 4'd0) begin
         if (off_size < 4'd8 && offset[8 * off_size - 1])
            offset = offset | (~64'd0 << (8 * off_size));
         cluster = prev_cluster + offset;
         prev_cluster = cluster;
      end
      // 2^47 clusters of 512 bytes or more exceed any 48-bit count
      if (len_accum >= 64'h8000_0000_0000 && cluster_bytes != 64'd0) begin
         copy = bytes_left;
      end else begin
         run_bytes = len_accum * cluster_bytes;
         copy = (run_bytes < {16'd0, bytes_left}) ? run_bytes[47:0] : bytes_left;
      end
      bytes_left = bytes_left - copy;
      if (off_size != 4'd0)
         r.disk_address = 64'(cfg_partition_start) * 64'd512 + cluster * cluster_bytes;
      r.run_clusters = len_accum;
      r.copy_bytes = copy;
      r.sparse_run = (off_size == 4'd0);
      parse_phase = PH_HEADER;
      return r;
   endfunction

   // Predictor: one accepted request in, at most one response out
   task automatic decode_run_byte(input logic [7:0] b, input logic start,
                                  output bit got, output run_result_type r);
      got = 1'b0;
      r = '0;
      if (start) begin
         prev_cluster = '0;
         bytes_left = cfg_file_bytes;
         parse_phase = PH_HEADER;
      end
      if (parse_phase != PH_HALT)
         live_requests++;
      case (parse_phase)
         PH_HEADER: begin
            if (b == 8'd0) begin
               r.end_of_list = 1'b1;
               got = 1'b1;
               parse_phase = PH_HALT;
            end else begin
               len_size = b[3:0];
               off_size = b[7:4];
               if (len_size > MAX_FIELD_BYTES || off_size > MAX_FIELD_BYTES) begin
                  r.malformed = 1'b1;
                  got = 1'b1;
                  parse_phase = PH_HALT;
               end else begin
                  len_accum = '0;
                  off_accum = '0;
                  field_count = '0;
                  if (len_size != 4'd0)
                     parse_phase = PH_LENGTH;
                  else
                     parse_phase = PH_OFFSET;
               end
            end
         end
         PH_LENGTH: begin
            len_accum = len_accum | (64'(b) << (8 * field_count[2:0]));
            field_count++;
            if (field_count >= len_size) begin
               if (off_size == 4'd0) begin
                  r = finish_run();
                  got = 1'b1;
               end else begin
                  field_count = '0;
                  parse_phase = PH_OFFSET;
               end
            end
         end
         PH_OFFSET: begin
            off_accum = off_accum | (64'(b) << (8 * field_count[2:0]));
            field_count++;
            if (field_count >= off_size) begin
               r = finish_run();
               got = 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   // Present one request and return once it is accepted
   task automatic send_req(input logic [7:0] b, input logic start);
      int gap;
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_run_byte <= b;
      req_list_start <= start;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic offer_byte(input logic [7:0] b, input logic start);
      bit got;
      run_result_type r;
      send_req(b, start);
      decode_run_byte(b, start, got, r);
      if (got)
         pending_runs.push_back(r);
   endtask

   // Drop valid, then wait for every response and the pipeline to empty
   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_runs.size() != 0)
         @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [47:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_CLUSTER_SECTORS: cfg_cluster_sectors = val[7:0];
         CSR_PARTITION_START: cfg_partition_start = val[31:0];
         CSR_FILE_BYTES:      cfg_file_bytes = val;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [7:0] sectors, input logic [31:0] part_start,
                             input logic [47:0] size);
      write_csr(CSR_CLUSTER_SECTORS, {40'd0, sectors});
      write_csr(CSR_PARTITION_START, {16'd0, part_start});
      write_csr(CSR_FILE_BYTES, size);
   endtask

   // One random run list: mostly well formed, some noise, cut-off runs
   // and oversize headers
   task automatic send_list();
      int kind, runs, k, n, total, nbytes;
      logic [3:0] len_sz, off_sz;
      logic [7:0] b;
      bit first;
      kind = $urandom_range(0, 19);
      first = 1'b1;
      if (kind == 0) begin
         repeat ($urandom_range(1, 12))
            offer_byte(8'($urandom), $urandom_range(0, 5) == 0);
         return;
      end
      runs = $urandom_range(0, 6);
      for (k = 0; k < runs; k++) begin
         len_sz = 4'($urandom_range(0, 8));
         off_sz = 4'($urandom_range(0, 8));
         if (len_sz == 4'd0 && off_sz == 4'd0)
            len_sz = 4'd1;
         offer_byte({off_sz, len_sz}, first);
         first = 1'b0;
         total = int'(len_sz) + int'(off_sz);
         // last run cut short; the next list start drops it
         nbytes = (kind == 1 && k == runs - 1) ? $urandom_range(0, total - 1) : total;
         for (n = 0; n < nbytes; n++) begin
            // upper length bytes mostly zero so copy limits both ways
            if (n < int'(len_sz) && n >= 2 && $urandom_range(0, 3) != 0)
               b = 8'd0;
            else
               b = 8'($urandom);
            offer_byte(b, 1'b0);
         end
         if (nbytes < total)
            return;
      end
      if (kind == 2) begin
         b = {4'($urandom_range(0, 15)), 4'($urandom_range(9, 15))};
         if ($urandom_range(0, 1) == 1)
            b = {b[3:0], b[7:4]};
         offer_byte(b, first);
      end else begin
         offer_byte(8'h00, first);
      end
      // trailing bytes are ignored until the next start
      repeat ($urandom_range(0, 2))
         offer_byte(8'($urandom), 1'b0);
   endtask

   // Receiver: random stall bursts, and one long hold-off on request
   initial begin
      int span;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (100) @(negedge clock);
            rsp_stall <= 1'b0;
            hold_off = 1'b0;
         end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            span = $urandom_range(1, 5);
            rsp_stall <= 1'b1;
            repeat (span) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Response checker
   always @(posedge clock) begin
      run_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_runs.size() == 0) begin
            report_mismatch("response with nothing expected");
         end else begin
            want = pending_runs.pop_front();
            check_field("disk_address", rsp_disk_address, want.disk_address);
            check_field("run_clusters", rsp_run_clusters, want.run_clusters);
            check_field("copy_bytes", 64'(rsp_copy_bytes), 64'(want.copy_bytes));
            check_field("sparse_run", 64'(rsp_sparse_run), 64'(want.sparse_run));
            check_field("end_of_list", 64'(rsp_end_of_list), 64'(want.end_of_list));
            check_field("malformed", 64'(rsp_malformed), 64'(want.malformed));
         end
      end
   end

   // Main sequence
   initial begin
      int ph;
      bit got;
      run_result_type r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_run_byte = '0;
      req_list_start = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_CLUSTER_SECTORS;
      csr_wdata = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed table
      set_config(8'd8, 32'd2048, 48'd20000);
      foreach (directed_rows[i]) begin
         send_req(directed_rows[i].run_byte, directed_rows[i].list_start);
         decode_run_byte(directed_rows[i].run_byte, directed_rows[i].list_start, got, r);
         if (directed_rows[i].typed)
            pending_runs.push_back(directed_rows[i].want);
         else if (got)
            pending_runs.push_back(r);
      end

      // random lists over several register settings
      for (ph = 0; ph < 8; ph++) begin
         drain_responses();
         case (ph)
            0: set_config(8'd1, 32'd0, 48'd0);
            1: set_config(8'd255, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
            2: set_config(8'd0, 32'($urandom), 48'($urandom_range(0, 1 << 20)));
            default: begin
               if ($urandom_range(0, 3) == 0)
                  set_config(8'($urandom), 32'($urandom), {16'($urandom), 32'($urandom)});
               else
                  set_config(8'($urandom), 32'($urandom), 48'($urandom_range(0, 1 << 22)));
            end
         endcase
         gaps_on = (ph != 4 && ph != 7);
         if (ph == 1)
            hold_off = 1'b1;
         while (live_requests < (ph + 1) * 150)
            send_list();
      end

      drain_responses();
      repeat (10) @(posedge clock);
      if (pending_runs.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_runs.size()));
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
